[src/ray_plane_intersect_assert.svh]
// assertion macros shared by the ray/plane intersection block
`ifndef RAY_PLANE_INTERSECT_ASSERT_SVH
`define RAY_PLANE_INTERSECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RPI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define RPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[src/rpi_pkg.sv]
// types, constants and helper functions of the ray/plane intersection block
`timescale 1ns / 1ps
package rpi_pkg;

   localparam int DivStages = 16;
   localparam int DivBitsPerStage = 2;

   localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32Min = 32'sh8000_0000;

   localparam logic signed [31:0] HeightReset  = 32'sd0;
   localparam logic signed [31:0] NormalXReset = 32'sd0;
   localparam logic signed [31:0] NormalYReset = -32'sd65536;
   localparam logic signed [31:0] NormalZReset = 32'sd0;

   // configuration register indexes
   typedef enum logic [1:0] {
      CsrPlaneHeight = 2'd0,
      CsrNormalX     = 2'd1,
      CsrNormalY     = 2'd2,
      CsrNormalZ     = 2'd3
   } rpi_csr_type;

   // per-ray data carried alongside the arithmetic
   typedef struct packed {
      logic               dneg;
      logic               nneg;
      logic               dzero;
      logic               ovf;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] tmin;
      logic signed [31:0] tmax;
   } rpi_side_type;

   // one result item
   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] hit_distance;
      logic               front_face;
      logic signed [31:0] face_normal_x;
      logic signed [31:0] face_normal_y;
      logic signed [31:0] face_normal_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } rpi_result_type;

   typedef struct packed {
      logic [63:0] rem;
      logic        qbit;
   } rpi_step_type;

   // one restoring division step
   function automatic rpi_step_type div_step(input logic [63:0] rem,
                                             input logic [63:0] den,
                                             input logic        bit_in);
      logic [64:0]  trial;
      rpi_step_type res;
      trial = {rem, bit_in};
      if (trial >= {1'b0, den}) begin
         res.rem  = 64'(trial - {1'b0, den});
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[63:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   // saturate a signed 49-bit value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      if (v > 49'(S32Max)) begin
         return S32Max;
      end else if (v < 49'(S32Min)) begin
         return S32Min;
      end
      return v[31:0];
   endfunction

   // negate with saturation at the most negative code
   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      if (v == S32Min) begin
         return S32Max;
      end
      return -v;
   endfunction

endpackage

[src/ray_plane_intersect.sv]
// top level of the ray/plane intersection block
`timescale 1ns / 1ps
// Ray/plane intersection, one request per clock while req_stall is low. Each accepted
// request enters the pipeline and its result passes through four stages of dot products
// and magnitudes, sixteen divider stages that each resolve two quotient bits, two
// stages for the distance window and hit point products, and the output register.
// Throughput is one result per cycle while the result channel does not stall.
// A two-entry output register and skid buffer decouple the sides, so a stall on
// the result channel is seen at req_stall only once both entries are full.
// Configuration writes are always ready and must happen while no request is in flight.
module ray_plane_intersect (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_origin_x,
   input  logic signed [31:0]  req_origin_y,
   input  logic signed [31:0]  req_origin_z,
   input  logic signed [31:0]  req_dir_x,
   input  logic signed [31:0]  req_dir_y,
   input  logic signed [31:0]  req_dir_z,
   input  logic signed [31:0]  req_dist_min,
   input  logic signed [31:0]  req_dist_max,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_is_hit,
   output logic signed [31:0]  rsp_hit_distance,
   output logic                rsp_front_face,
   output logic signed [31:0]  rsp_face_normal_x,
   output logic signed [31:0]  rsp_face_normal_y,
   output logic signed [31:0]  rsp_face_normal_z,
   output logic signed [31:0]  rsp_point_x,
   output logic signed [31:0]  rsp_point_y,
   output logic signed [31:0]  rsp_point_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  rpi_pkg::rpi_csr_type csr_index,
   input  logic [31:0]         csr_data
);
   import rpi_pkg::*;

   `include "ray_plane_intersect_assert.svh"

   // configuration registers
   logic signed [31:0] height_ff, normal_x_ff, normal_y_ff, normal_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= HeightReset;
         normal_x_ff <= NormalXReset;
         normal_y_ff <= NormalYReset;
         normal_z_ff <= NormalZReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrPlaneHeight: height_ff   <= csr_data;
            CsrNormalX:     normal_x_ff <= csr_data;
            CsrNormalY:     normal_y_ff <= csr_data;
            CsrNormalZ:     normal_z_ff <= csr_data;
            default:        height_ff   <= height_ff;
         endcase
      end
   end

   // pipeline advances while the skid entry is free
   logic en, skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   rpi_side_type req_side;

   always_comb begin
      req_side       = '0;
      req_side.ox    = req_origin_x;
      req_side.oy    = req_origin_y;
      req_side.oz    = req_origin_z;
      req_side.dx    = req_dir_x;
      req_side.dy    = req_dir_y;
      req_side.dz    = req_dir_z;
      req_side.tmin  = req_dist_min;
      req_side.tmax  = req_dist_max;
   end

   logic         dot_valid, div_valid, pt_valid;
   logic [63:0]  dot_rem, dot_dmag;
   logic [15:0]  dot_nlow;
   logic [31:0]  div_quo;
   rpi_side_type dot_side, div_side;
   rpi_result_type pt_result;

   rpi_dot u_dot (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid && !req_stall),
      .in_side      (req_side),
      .plane_height (height_ff),
      .normal_x     (normal_x_ff),
      .normal_y     (normal_y_ff),
      .normal_z     (normal_z_ff),
      .out_valid    (dot_valid),
      .out_rem      (dot_rem),
      .out_nlow     (dot_nlow),
      .out_dmag     (dot_dmag),
      .out_side     (dot_side)
   );

   rpi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dot_valid),
      .in_rem    (dot_rem),
      .in_nlow   (dot_nlow),
      .in_dmag   (dot_dmag),
      .in_side   (dot_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   rpi_point u_point (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (div_valid),
      .in_quo     (div_quo),
      .in_side    (div_side),
      .normal_x   (normal_x_ff),
      .normal_y   (normal_y_ff),
      .normal_z   (normal_z_ff),
      .out_valid  (pt_valid),
      .out_result (pt_result)
   );

   // output register with skid entry
   logic           out_valid_ff, pop, push;
   rpi_result_type out_ff, skid_ff;

   assign pop  = out_valid_ff && !rsp_stall;
   assign push = en && pt_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!out_valid_ff || pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= pt_result;
         end else begin
            skid_ff <= pt_result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_hit        = out_ff.is_hit;
   assign rsp_hit_distance  = out_ff.hit_distance;
   assign rsp_front_face    = out_ff.front_face;
   assign rsp_face_normal_x = out_ff.face_normal_x;
   assign rsp_face_normal_y = out_ff.face_normal_y;
   assign rsp_face_normal_z = out_ff.face_normal_z;
   assign rsp_point_x       = out_ff.point_x;
   assign rsp_point_y       = out_ff.point_y;
   assign rsp_point_z       = out_ff.point_z;

   // checks
   `RPI_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RPI_ASSERT_NOW(a_miss_zero, clock, reset, out_valid_ff && !out_ff.is_hit, (out_ff.hit_distance == 0) && (out_ff.point_x == 0) && !out_ff.front_face)
   `RPI_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff && out_valid_ff)

endmodule

[src/rpi_dot.sv]
// dot products, magnitudes and quotient overflow test, four stages
`timescale 1ns / 1ps
module rpi_dot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rpi_pkg::rpi_side_type in_side,
   input  logic signed [31:0]   plane_height,
   input  logic signed [31:0]   normal_x,
   input  logic signed [31:0]   normal_y,
   input  logic signed [31:0]   normal_z,
   output logic                 out_valid,
   output logic [63:0]          out_rem,
   output logic [15:0]          out_nlow,
   output logic [63:0]          out_dmag,
   output rpi_pkg::rpi_side_type out_side
);
   import rpi_pkg::*;

   logic [3:0] valid_ff;

   // stage 1: products
   logic signed [32:0] neg_ox, rel_y, neg_oz;
   logic signed [63:0] pd_x_ff, pd_y_ff, pd_z_ff;
   logic signed [64:0] pn_x_ff, pn_y_ff, pn_z_ff;
   logic signed [63:0] pd_x_in, pd_y_in, pd_z_in;
   logic signed [64:0] pn_x_in, pn_y_in, pn_z_in;
   rpi_side_type       side1_ff;

   assign neg_ox  = -$signed({in_side.ox[31], in_side.ox});
   assign rel_y   = $signed({plane_height[31], plane_height})
                  - $signed({in_side.oy[31], in_side.oy});
   assign neg_oz  = -$signed({in_side.oz[31], in_side.oz});
   assign pd_x_in = in_side.dx * normal_x;
   assign pd_y_in = in_side.dy * normal_y;
   assign pd_z_in = in_side.dz * normal_z;
   assign pn_x_in = neg_ox * normal_x;
   assign pn_y_in = rel_y * normal_y;
   assign pn_z_in = neg_oz * normal_z;

   // stage 2: sums
   logic signed [65:0] d_ff, d_in;
   logic signed [66:0] n_ff, n_in;
   rpi_side_type       side2_ff;

   assign d_in = 66'(pd_x_ff) + 66'(pd_y_ff) + 66'(pd_z_ff);
   assign n_in = 67'(pn_x_ff) + 67'(pn_y_ff) + 67'(pn_z_ff);

   // stage 3: signs and magnitudes
   logic [63:0]  dmag3_ff, dmag3_in;
   logic [64:0]  nmag3_ff, nmag3_in;
   rpi_side_type side3_ff, side3_in;

   assign dmag3_in = d_ff[65] ? 64'(-d_ff) : 64'(d_ff);
   assign nmag3_in = n_ff[66] ? 65'(-n_ff) : 65'(n_ff);
   always_comb begin
      side3_in       = side2_ff;
      side3_in.dneg  = d_ff[65];
      side3_in.nneg  = n_ff[66];
      side3_in.dzero = (d_ff == '0);
   end

   // stage 4: quotient overflow and divider seed
   logic [63:0]  rem4_ff, dmag4_ff;
   logic [15:0]  nlow4_ff;
   rpi_side_type side4_ff, side4_in;

   always_comb begin
      side4_in     = side3_ff;
      side4_in.ovf = ({15'd0, nmag3_ff[64:16]} >= dmag3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      if (en) begin
         pd_x_ff  <= pd_x_in;
         pd_y_ff  <= pd_y_in;
         pd_z_ff  <= pd_z_in;
         pn_x_ff  <= pn_x_in;
         pn_y_ff  <= pn_y_in;
         pn_z_ff  <= pn_z_in;
         side1_ff <= in_side;
         d_ff     <= d_in;
         n_ff     <= n_in;
         side2_ff <= side1_ff;
         dmag3_ff <= dmag3_in;
         nmag3_ff <= nmag3_in;
         side3_ff <= side3_in;
         rem4_ff  <= {15'd0, nmag3_ff[64:16]};
         nlow4_ff <= nmag3_ff[15:0];
         dmag4_ff <= dmag3_ff;
         side4_ff <= side4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_rem   = rem4_ff;
   assign out_nlow  = nlow4_ff;
   assign out_dmag  = dmag4_ff;
   assign out_side  = side4_ff;

endmodule

[src/rpi_div.sv]
// pipelined restoring divider, two quotient bits per stage
`timescale 1ns / 1ps
module rpi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [63:0]          in_rem,
   input  logic [15:0]          in_nlow,
   input  logic [63:0]          in_dmag,
   input  rpi_pkg::rpi_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_quo,
   output rpi_pkg::rpi_side_type out_side
);
   import rpi_pkg::*;

   logic         valid_ff [DivStages+1];
   logic [63:0]  rem_ff   [DivStages+1];
   logic [15:0]  nlow_ff  [DivStages+1];
   logic [63:0]  dmag_ff  [DivStages+1];
   logic [31:0]  quo_ff   [DivStages+1];
   rpi_side_type side_ff  [DivStages+1];

   // stage 0 is the divider input
   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = in_rem;
   assign nlow_ff[0]  = in_nlow;
   assign dmag_ff[0]  = in_dmag;
   assign quo_ff[0]   = '0;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < DivStages; k++) begin : g_stage
      rpi_step_type step_a, step_b;

      // dividend bits enter from the top of the low numerator word
      assign step_a = div_step(rem_ff[k], dmag_ff[k], nlow_ff[k][15]);
      assign step_b = div_step(step_a.rem, dmag_ff[k], nlow_ff[k][14]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            rem_ff[k+1]  <= step_b.rem;
            nlow_ff[k+1] <= {nlow_ff[k][13:0], 2'b00};
            dmag_ff[k+1] <= dmag_ff[k];
            quo_ff[k+1]  <= {quo_ff[k][29:0], step_a.qbit, step_b.qbit};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[DivStages];
   assign out_quo   = quo_ff[DivStages];
   assign out_side  = side_ff[DivStages];

endmodule

[src/rpi_point.sv]
// signed distance, window test, hit point products and result assembly
`timescale 1ns / 1ps
module rpi_point (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [31:0]            in_quo,
   input  rpi_pkg::rpi_side_type   in_side,
   input  logic signed [31:0]     normal_x,
   input  logic signed [31:0]     normal_y,
   input  logic signed [31:0]     normal_z,
   output logic                   out_valid,
   output rpi_pkg::rpi_result_type out_result
);
   import rpi_pkg::*;

   logic [1:0] valid_ff;

   // stage a: saturated signed distance and window test
   logic [32:0]        qsat;
   logic signed [31:0] t_in, t_a_ff, t_b_ff;
   logic               hit_in, hit_a_ff, hit_b_ff;
   rpi_side_type       side_a_ff, side_b_ff;

   always_comb begin
      qsat = in_side.ovf ? 33'h1_0000_0000 : {1'b0, in_quo};
      if (qsat > 33'h0_8000_0000) begin
         qsat = 33'h0_8000_0000;
      end
      if (in_side.nneg != in_side.dneg) begin
         t_in = qsat[31] ? S32Min : -$signed(qsat[31:0]);
      end else begin
         t_in = qsat[31] ? S32Max : $signed(qsat[31:0]);
      end
      hit_in = !in_side.dzero && (t_in >= in_side.tmin) && (t_in <= in_side.tmax);
   end

   // stage b: t times direction
   logic signed [63:0] prod_x_ff, prod_y_ff, prod_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
      if (en) begin
         t_a_ff    <= t_in;
         hit_a_ff  <= hit_in;
         side_a_ff <= in_side;
         prod_x_ff <= t_a_ff * side_a_ff.dx;
         prod_y_ff <= t_a_ff * side_a_ff.dy;
         prod_z_ff <= t_a_ff * side_a_ff.dz;
         t_b_ff    <= t_a_ff;
         hit_b_ff  <= hit_a_ff;
         side_b_ff <= side_a_ff;
      end
   end

   // floor scaling, origin add and zeroing on a miss
   logic signed [48:0] sum_x, sum_y, sum_z;

   assign sum_x = 49'(side_b_ff.ox) + 49'($signed(prod_x_ff[63:16]));
   assign sum_y = 49'(side_b_ff.oy) + 49'($signed(prod_y_ff[63:16]));
   assign sum_z = 49'(side_b_ff.oz) + 49'($signed(prod_z_ff[63:16]));

   always_comb begin
      out_result = '0;
      if (hit_b_ff) begin
         out_result.is_hit        = 1'b1;
         out_result.hit_distance  = t_b_ff;
         out_result.front_face    = side_b_ff.dneg;
         out_result.face_normal_x = side_b_ff.dneg ? normal_x : neg_sat(normal_x);
         out_result.face_normal_y = side_b_ff.dneg ? normal_y : neg_sat(normal_y);
         out_result.face_normal_z = side_b_ff.dneg ? normal_z : neg_sat(normal_z);
         out_result.point_x       = sat32(sum_x);
         out_result.point_y       = sat32(sum_y);
         out_result.point_z       = sat32(sum_z);
      end
   end

   assign out_valid = valid_ff[1];

endmodule
